>>> rtl/core/image_rotate_nearest_defines.svh
// assertion macros shared by the rotator checker
`ifndef IMAGE_ROTATE_NEAREST_DEFINES_SVH
`define IMAGE_ROTATE_NEAREST_DEFINES_SVH

// same-cycle implication, masked while in reset
`define IRN_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("irn: same-cycle check failed");

// next-cycle implication, masked while in reset
`define IRN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("irn: next-cycle check failed");

// what must hold in the cycle after reset is seen low
`define IRN_ASSERT_RST(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("irn: reset check failed");

`endif

>>> rtl/core/irn_pkg.sv
// shared types and constants of the nearest-neighbor rotator
package irn_pkg;

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int SIZE_W     = 8;
    localparam int TRIG_W     = 16;
    localparam int POS_W      = 7;
    localparam int PIX_W      = 4;

    // rotation datapath
    localparam int DIFF_W     = 10;
    localparam int PROD_W     = TRIG_W + DIFF_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int FRAC_W     = 15;
    localparam int CRD_W      = SUM_W - FRAC_W;
    localparam int ROUND_HALF = 1 << (FRAC_W - 1);

    // queue between front and back
    localparam int Q_DEPTH = 8;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [SIZE_W-1:0] RST_WIDTH  = 8'd120;
    localparam logic [SIZE_W-1:0] RST_HEIGHT = 8'd120;
    localparam logic [TRIG_W-1:0] RST_COS    = 16'sd16384;
    localparam logic [TRIG_W-1:0] RST_SIN    = 16'sd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 8'd0,
        REG_HEIGHT = 8'd1,
        REG_COS    = 8'd2,
        REG_SIN    = 8'd3
    } t_cfg_reg;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_QUERY = 1'b1
    } t_action;

    typedef struct packed {
        t_action          action;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [PIX_W-1:0] pixel_in;
    } t_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             inside_res;
    } t_res;

    typedef struct packed {
        logic [SIZE_W-1:0]        image_width;
        logic [SIZE_W-1:0]        image_height;
        logic signed [TRIG_W-1:0] cos_value;
        logic signed [TRIG_W-1:0] sin_value;
    } t_cfg;

    // hit: store enable on a write, mapped point inside the image on a query
    typedef struct packed {
        t_action           kind;
        logic              hit;
        logic [SIZE_W-1:0] col;
        logic [SIZE_W-1:0] row;
        logic [PIX_W-1:0]  pixel;
    } t_cmd;

endpackage

>>> rtl/core/irn_front.sv
// front end: accepts words, maps query coordinates back into the source image
module irn_front #(
    parameter int MAX_WIDTH  = irn_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = irn_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  irn_pkg::t_item                i_item,
    input  irn_pkg::t_cfg                 i_cfg,
    input  logic [irn_pkg::Q_CNT_W-1:0]   i_q_level,
    output logic                          o_push,
    output irn_pkg::t_cmd                 o_cmd
);
    import irn_pkg::*;

    localparam int LIM_W = $clog2(MAX_WIDTH + MAX_HEIGHT + 1) + SIZE_W;
    localparam logic [LIM_W-1:0] LIM_X = LIM_W'(MAX_WIDTH);
    localparam logic [LIM_W-1:0] LIM_Y = LIM_W'(MAX_HEIGHT);

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                   input logic [LIM_W-1:0] lim);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (LIM_W'(v) > lim) begin
            r = lim[SIZE_W-1:0];
        end else begin
            r = v;
        end
        return r;
    endfunction

    logic                     acc;
    logic [SIZE_W-1:0]        w_eff, h_eff, wm1, hm1;
    logic signed [DIFF_W-1:0] dx, dy;
    logic                     in_hit;

    // stage 1: decode and centre offsets
    logic                     r1_valid;
    t_action                  r1_kind;
    logic                     r1_hit;
    logic [POS_W-1:0]         r1_col, r1_row;
    logic [PIX_W-1:0]         r1_pix;
    logic [SIZE_W-1:0]        r1_wm1, r1_hm1;
    logic signed [DIFF_W-1:0] r1_dx, r1_dy;

    // stage 2: products
    logic                     r2_valid;
    t_action                  r2_kind;
    logic                     r2_hit;
    logic [POS_W-1:0]         r2_col, r2_row;
    logic [PIX_W-1:0]         r2_pix;
    logic [SIZE_W-1:0]        r2_wm1, r2_hm1;
    logic signed [PROD_W-1:0] r2_s_dx, r2_c_dy, r2_c_dx, r2_s_dy;
    logic signed [PROD_W-1:0] n_s_dx, n_c_dy, n_c_dx, n_s_dy;

    // stage 3: sums
    logic                     r3_valid;
    t_action                  r3_kind;
    logic                     r3_hit;
    logic [POS_W-1:0]         r3_col, r3_row;
    logic [PIX_W-1:0]         r3_pix;
    logic [SIZE_W-1:0]        r3_wm1, r3_hm1;
    logic signed [SUM_W-1:0]  r3_nx, r3_ny;
    logic signed [SUM_W-1:0]  e_s_dx, e_c_dy, e_c_dx, e_s_dy, bias_x, bias_y;
    logic signed [SUM_W-1:0]  n_nx, n_ny;

    // rounding and bounds check ahead of the queue
    logic [SUM_W-1:0]         rx, ry;
    logic [CRD_W-1:0]         sx, sy;
    logic                     x_in, y_in;
    logic [Q_CNT_W:0]         occupancy;

    assign occupancy = (Q_CNT_W + 1)'(i_q_level) + (Q_CNT_W + 1)'(r1_valid)
                     + (Q_CNT_W + 1)'(r2_valid) + (Q_CNT_W + 1)'(r3_valid);
    assign o_stall   = occupancy >= (Q_CNT_W + 1)'(Q_DEPTH);
    assign acc       = i_valid && !o_stall;

    always_comb begin
        w_eff = eff_size(i_cfg.image_width, LIM_X);
        h_eff = eff_size(i_cfg.image_height, LIM_Y);
        wm1   = w_eff - SIZE_W'(1);
        hm1   = h_eff - SIZE_W'(1);
        dx    = $signed(DIFF_W'({i_item.pos_x, 1'b0})) - $signed(DIFF_W'(wm1));
        dy    = $signed(DIFF_W'({i_item.pos_y, 1'b0})) - $signed(DIFF_W'(hm1));
        if (i_item.action == ACT_WRITE) begin
            in_hit = (LIM_W'(i_item.pos_x) < LIM_X) && (LIM_W'(i_item.pos_y) < LIM_Y);
        end else begin
            in_hit = (SIZE_W'(i_item.pos_x) < w_eff) && (SIZE_W'(i_item.pos_y) < h_eff);
        end
    end

    always_comb begin
        n_s_dx = i_cfg.sin_value * r1_dx;
        n_c_dy = i_cfg.cos_value * r1_dy;
        n_c_dx = i_cfg.cos_value * r1_dx;
        n_s_dy = i_cfg.sin_value * r1_dy;
    end

    always_comb begin
        e_s_dx = r2_s_dx;
        e_c_dy = r2_c_dy;
        e_c_dx = r2_c_dx;
        e_s_dy = r2_s_dy;
        bias_x = SUM_W'({r2_wm1, {(FRAC_W - 1){1'b0}}});
        bias_y = SUM_W'({r2_hm1, {(FRAC_W - 1){1'b0}}});
        n_nx   = bias_x + e_s_dx + e_c_dy;
        n_ny   = bias_y - e_c_dx + e_s_dy;
    end

    // half away from zero: add one half, less one when negative, then floor
    always_comb begin
        rx   = r3_nx + SUM_W'(ROUND_HALF) - SUM_W'(r3_nx[SUM_W-1]);
        ry   = r3_ny + SUM_W'(ROUND_HALF) - SUM_W'(r3_ny[SUM_W-1]);
        sx   = rx[SUM_W-1:FRAC_W];
        sy   = ry[SUM_W-1:FRAC_W];
        x_in = !sx[CRD_W-1] && (sx <= CRD_W'(r3_wm1));
        y_in = !sy[CRD_W-1] && (sy <= CRD_W'(r3_hm1));
    end

    always_comb begin
        o_push      = r3_valid;
        o_cmd.kind  = r3_kind;
        o_cmd.pixel = r3_pix;
        if (r3_kind == ACT_QUERY) begin
            o_cmd.hit = r3_hit && x_in && y_in;
            o_cmd.col = sx[SIZE_W-1:0];
            o_cmd.row = sy[SIZE_W-1:0];
        end else begin
            o_cmd.hit = r3_hit;
            o_cmd.col = SIZE_W'(r3_col);
            o_cmd.row = SIZE_W'(r3_row);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= acc;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_kind <= i_item.action;
        r1_hit  <= in_hit;
        r1_col  <= i_item.pos_x;
        r1_row  <= i_item.pos_y;
        r1_pix  <= i_item.pixel_in;
        r1_wm1  <= wm1;
        r1_hm1  <= hm1;
        r1_dx   <= dx;
        r1_dy   <= dy;

        r2_kind <= r1_kind;
        r2_hit  <= r1_hit;
        r2_col  <= r1_col;
        r2_row  <= r1_row;
        r2_pix  <= r1_pix;
        r2_wm1  <= r1_wm1;
        r2_hm1  <= r1_hm1;
        r2_s_dx <= n_s_dx;
        r2_c_dy <= n_c_dy;
        r2_c_dx <= n_c_dx;
        r2_s_dy <= n_s_dy;

        r3_kind <= r2_kind;
        r3_hit  <= r2_hit;
        r3_col  <= r2_col;
        r3_row  <= r2_row;
        r3_pix  <= r2_pix;
        r3_wm1  <= r2_wm1;
        r3_hm1  <= r2_hm1;
        r3_nx   <= n_nx;
        r3_ny   <= n_ny;
    end

endmodule

>>> rtl/core/irn_queue.sv
// small command queue between the front end and the frame store
module irn_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  irn_pkg::t_cmd               i_cmd,
    input  logic                        i_pop,
    output logic                        o_valid,
    output irn_pkg::t_cmd               o_cmd,
    output logic [irn_pkg::Q_CNT_W-1:0] o_level
);
    import irn_pkg::*;

    t_cmd               r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_valid = r_count != '0;
    assign o_cmd   = r_slot[r_rd_ptr];
    assign o_level = r_count;

    // the front end reserves room before it takes a word, so a push never overflows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            r_count <= r_count + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> rtl/core/irn_back.sv
// back end: frame store writes and reads, result register
module irn_back #(
    parameter int MAX_WIDTH  = irn_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = irn_pkg::DEF_MAX_HEIGHT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  irn_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output irn_pkg::t_res o_res
);
    import irn_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [PIX_W-1:0]  r_store [DEPTH];
    logic [PIX_W-1:0]  r_rdata;
    logic              r_a_valid, r_a_hit;
    logic              r_o_valid;
    t_res              r_o_res;
    logic              out_ready, a_ready;
    logic              do_write, do_read;
    logic [ADDR_W-1:0] addr;

    assign out_ready = !r_o_valid || !i_stall;
    assign a_ready   = !r_a_valid || out_ready;
    assign o_pop     = i_q_valid && a_ready;
    assign do_write  = o_pop && (i_cmd.kind == ACT_WRITE) && i_cmd.hit;
    assign do_read   = o_pop && (i_cmd.kind == ACT_QUERY) && i_cmd.hit;
    assign addr      = ADDR_W'(32'(i_cmd.row) * MAX_WIDTH + 32'(i_cmd.col));
    assign o_valid   = r_o_valid;
    assign o_res     = r_o_res;

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_store[addr] <= i_cmd.pixel;
        end
        if (do_read) begin
            r_rdata <= r_store[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= o_pop && (i_cmd.kind == ACT_QUERY);
            end
            if (out_ready) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready) begin
            r_a_hit <= i_cmd.hit;
        end
        if (out_ready) begin
            r_o_res.pixel_out  <= r_a_hit ? r_rdata : '0;
            r_o_res.inside_res <= r_a_hit;
        end
    end

endmodule

>>> rtl/core/image_rotate_nearest.sv
// top level of the nearest-neighbor image rotator
// path: an accepted query word passes the front stages, the queue, the frame store read and the result register
// throughput: one word per cycle while nothing stalls, set by the frame store's single port
// writes give no result; a queue of eight commands lets front and back stall apart
// reset: synchronous active-low, clears control and loads the size and angle registers
module image_rotate_nearest #(
    parameter int MAX_WIDTH  = irn_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = irn_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [irn_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [irn_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  irn_pkg::t_item                  i_item,
    output logic                            o_valid,
    input  logic                            i_stall,
    output irn_pkg::t_res                   o_res
);
    import irn_pkg::*;

    t_cfg               r_cfg;
    logic               push, pop, q_valid;
    t_cmd               push_cmd, q_cmd;
    logic [Q_CNT_W-1:0] q_level;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= RST_WIDTH;
            r_cfg.image_height <= RST_HEIGHT;
            r_cfg.cos_value    <= RST_COS;
            r_cfg.sin_value    <= RST_SIN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_WIDTH:  r_cfg.image_width  <= i_cfg_data[SIZE_W-1:0];
                REG_HEIGHT: r_cfg.image_height <= i_cfg_data[SIZE_W-1:0];
                REG_COS:    r_cfg.cos_value    <= i_cfg_data[TRIG_W-1:0];
                REG_SIN:    r_cfg.sin_value    <= i_cfg_data[TRIG_W-1:0];
                default:    ;
            endcase
        end
    end

    irn_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_item    (i_item),
        .i_cfg     (r_cfg),
        .i_q_level (q_level),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    irn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .o_level (q_level)
    );

    irn_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (q_cmd),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_res     (o_res)
    );

endmodule

>>> rtl/core/irn_checker.sv
// port-level checker for the rotator and its bind to the top level
`include "image_rotate_nearest_defines.svh"

module irn_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_valid,
    input logic          i_stall,
    input irn_pkg::t_res o_res
);
    import irn_pkg::*;

    // a stalled result stays offered
    `IRN_ASSERT_NEXT(a_res_held, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    // a stalled result keeps its fields
    `IRN_ASSERT_NEXT(a_res_stable, i_clk, i_rst_n, o_valid && i_stall, $stable(o_res))
    // a point mapped outside the source is transparent
    `IRN_ASSERT_SAME(a_outside_clear, i_clk, i_rst_n, o_valid && !o_res.inside_res, o_res.pixel_out == '0)
    // no result right after reset
    `IRN_ASSERT_RST(a_rst_idle, i_clk, i_rst_n, !o_valid)

endmodule

bind image_rotate_nearest irn_checker u_irn_checker (.*);

>>> dv/image_rotate_checker.sv
// checker of the nearest-neighbor rotator: frame store copy, result prediction and comparison
`timescale 1ns / 1ps

module image_rotate_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [irn_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [irn_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    input  logic                           i_stall_in,
    input  irn_pkg::t_item                 i_item,
    input  logic                           i_res_valid,
    input  logic                           i_res_stall,
    input  irn_pkg::t_res                  i_res,
    output int                             o_errors,
    output int                             o_pending
);
    import irn_pkg::*;

    localparam int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

    logic [PIX_W-1:0] frame_mem [STORE_DEPTH];
    t_cfg             rot_regs;
    t_res             rotated_pixels[$];
    int               mismatch_cnt = 0;

    initial begin
        for (int i = 0; i < STORE_DEPTH; i++) frame_mem[i] = '0;
    end

    function automatic longint clamp_size(logic [SIZE_W-1:0] v, longint maxv);
        if (v == 0) return 1;
        if (longint'(v) > maxv) return maxv;
        return longint'(v);
    endfunction

    // divide by 2^15, ties away from zero
    function automatic longint round_q15(longint n);
        if (n >= 0) return (n + 16384) / 32768;
        return -((-n + 16384) / 32768);
    endfunction

    function automatic t_res rotate_lookup(t_item it);
        longint w, h, c, s, dx, dy, sx, sy;
        t_res   r;
        r = '0;
        w = clamp_size(rot_regs.image_width, DEF_MAX_WIDTH);
        h = clamp_size(rot_regs.image_height, DEF_MAX_HEIGHT);
        if (longint'(it.pos_x) < w && longint'(it.pos_y) < h) begin
            c  = rot_regs.cos_value;
            s  = rot_regs.sin_value;
            dx = 2 * longint'(it.pos_x) - (w - 1);
            dy = 2 * longint'(it.pos_y) - (h - 1);
            sx = round_q15((w - 1) * 16384 + s * dx + c * dy);
            sy = round_q15((h - 1) * 16384 - c * dx + s * dy);
            if (sx >= 0 && sy >= 0 && sx < w && sy < h) begin
                r.inside_res = 1'b1;
                r.pixel_out  = frame_mem[sy * DEF_MAX_WIDTH + sx];
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_res want;
        if (!i_rst_n) begin
            rot_regs.image_width  = RST_WIDTH;
            rot_regs.image_height = RST_HEIGHT;
            rot_regs.cos_value    = RST_COS;
            rot_regs.sin_value    = RST_SIN;
            rotated_pixels.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_WIDTH:  rot_regs.image_width  = i_cfg_data[SIZE_W-1:0];
                    REG_HEIGHT: rot_regs.image_height = i_cfg_data[SIZE_W-1:0];
                    REG_COS:    rot_regs.cos_value    = i_cfg_data;
                    REG_SIN:    rot_regs.sin_value    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !i_stall_in) begin
                if (i_item.action == ACT_WRITE)
                    frame_mem[int'(i_item.pos_y) * DEF_MAX_WIDTH + int'(i_item.pos_x)] =
                        i_item.pixel_in;
                else
                    rotated_pixels = {rotated_pixels, rotate_lookup(i_item)};
            end
            if (i_res_valid && !i_res_stall) begin
                if (rotated_pixels.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: unexpected result, expected none, got pixel %0d inside %0d",
                             $time, i_res.pixel_out, i_res.inside_res);
                end else begin
                    want = rotated_pixels.pop_front();
                    if (i_res.pixel_out !== want.pixel_out) begin
                        mismatch_cnt++;
                        $display("%0t: pixel_out mismatch, expected %0d, got %0d",
                                 $time, want.pixel_out, i_res.pixel_out);
                    end
                    if (i_res.inside_res !== want.inside_res) begin
                        mismatch_cnt++;
                        $display("%0t: inside_res mismatch, expected %0d, got %0d",
                                 $time, want.inside_res, i_res.inside_res);
                    end
                end
            end
        end
        o_pending <= rotated_pixels.size();
        o_errors  <= mismatch_cnt;
    end

endmodule

>>> dv/tb_top.sv
// testbench top of the nearest-neighbor rotator: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_top;
    import irn_pkg::*;

    localparam int                   RANDOM_PHASES  = 10;
    localparam int                   PHASE_WORDS    = 112;
    localparam int                   DRAIN_CYCLES   = 24;
    localparam int                   IDLE_LIMIT     = 2000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'hFF;
    localparam int                   STORE_DEPTH    = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  item_valid = 1'b0;
    logic                  item_stall;
    t_item                 item_word  = '0;
    logic                  res_valid;
    logic                  res_stall  = 1'b0;
    t_res                  res_word;
    int                    err_count;
    int                    pend_count;

    bit                    written [STORE_DEPTH];
    bit                    calm = 1'b0;
    int                    cur_w;
    int                    cur_h;
    longint                cur_c;
    longint                cur_s;
    int                    idle_cycles = 0;
    int unsigned           stall_left = 0;
    int unsigned           stall_gap;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    image_rotate_nearest u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_valid     (item_valid),
        .o_stall     (item_stall),
        .i_item      (item_word),
        .o_valid     (res_valid),
        .i_stall     (res_stall),
        .o_res       (res_word)
    );

    image_rotate_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_valid     (item_valid),
        .i_stall_in  (item_stall),
        .i_item      (item_word),
        .i_res_valid (res_valid),
        .i_res_stall (res_stall),
        .i_res       (res_word),
        .o_errors    (err_count),
        .o_pending   (pend_count)
    );

    // mostly no gap, some short ones, a few long ones
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int eff_size(logic [CFG_DATA_W-1:0] d);
        if (d[SIZE_W-1:0] == 0) return 1;
        if (int'(d[SIZE_W-1:0]) > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
        return int'(d[SIZE_W-1:0]);
    endfunction

    // divide by 2^15, ties away from zero
    function automatic longint q15_round(longint n);
        if (n >= 0) return (n + 16384) / 32768;
        return -((-n + 16384) / 32768);
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        if ($urandom_range(0, 3) == 0) return '0;
        return PIX_W'($urandom_range(0, 15));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_size();
        logic [CFG_DATA_W-1:0] d;
        int unsigned           r;
        r = $urandom_range(0, 99);
        d[15:8] = 8'($urandom_range(0, 255));
        if (r < 8)       d[7:0] = 8'd0;
        else if (r < 14) d[7:0] = 8'd128;
        else if (r < 20) d[7:0] = 8'($urandom_range(129, 255));
        else             d[7:0] = 8'($urandom_range(1, 32));
        return d;
    endfunction

    function automatic logic [TRIG_W-1:0] pick_trig();
        logic [TRIG_W-1:0] t;
        int unsigned       r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            case ($urandom_range(0, 2))
                0:       t = 16'sd16384;
                1:       t = 16'sd0;
                default: t = -16'sd16384;
            endcase
        end else if (r < 30) begin
            t = TRIG_W'($urandom_range(0, 65535));
        end else begin
            t = TRIG_W'($urandom_range(0, 32768));
            t = t - 16'd16384;
        end
        return t;
    endfunction

    task automatic send_item(input t_item it);
        int unsigned g;
        g = gap_len();
        if (g != 0) begin
            item_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        item_valid <= 1'b1;
        item_word  <= it;
        do @(posedge clk); while (item_stall);
    endtask

    task automatic write_pixel(input int x, input int y, input logic [PIX_W-1:0] p);
        t_item it;
        it.action   = ACT_WRITE;
        it.pos_x    = POS_W'(x);
        it.pos_y    = POS_W'(y);
        it.pixel_in = p;
        written[y * DEF_MAX_WIDTH + x] = 1'b1;
        send_item(it);
    endtask

    // the source pixel a query maps to is written ahead of the query
    task automatic query_pixel(input int x, input int y);
        t_item  it;
        longint dx, dy, sx, sy;
        if (x < cur_w && y < cur_h) begin
            dx = 2 * longint'(x) - longint'(cur_w - 1);
            dy = 2 * longint'(y) - longint'(cur_h - 1);
            sx = q15_round(longint'(cur_w - 1) * 16384 + cur_s * dx + cur_c * dy);
            sy = q15_round(longint'(cur_h - 1) * 16384 - cur_c * dx + cur_s * dy);
            if (sx >= 0 && sy >= 0 && sx < cur_w && sy < cur_h &&
                !written[sy * DEF_MAX_WIDTH + sx])
                write_pixel(int'(sx), int'(sy), pick_pixel());
        end
        it.action   = ACT_QUERY;
        it.pos_x    = POS_W'(x);
        it.pos_y    = POS_W'(y);
        it.pixel_in = PIX_W'($urandom_range(0, 15));
        send_item(it);
    endtask

    task automatic cfg_word(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                                input logic [TRIG_W-1:0] c, input logic [TRIG_W-1:0] s,
                                input bit with_unused);
        if (with_unused) cfg_word(CFG_UNUSED_IDX, 16'hFFFF);
        cfg_word(REG_WIDTH, w);
        cfg_word(REG_HEIGHT, h);
        cfg_word(REG_COS, c);
        cfg_word(REG_SIN, s);
        cfg_valid <= 1'b0;
        cur_w = eff_size(w);
        cur_h = eff_size(h);
        cur_c = longint'($signed(c));
        cur_s = longint'($signed(s));
    endtask

    // wait out all queries, then let trailing writes retire
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pend_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_item();
        if ($urandom_range(0, 99) < 35) begin
            if ($urandom_range(0, 99) < 60)
                write_pixel($urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1),
                            pick_pixel());
            else
                write_pixel($urandom_range(0, 127), $urandom_range(0, 127), pick_pixel());
        end else if ($urandom_range(0, 99) < 75) begin
            query_pixel($urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1));
        end else begin
            query_pixel($urandom_range(0, 127), $urandom_range(0, 127));
        end
    endtask

    always @(posedge clk) begin : result_stall
        if (!rst_n) begin
            res_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (res_stall) begin
            res_stall  <= 1'b0;
            stall_left <= $urandom_range(0, 7);
        end else begin
            stall_gap = gap_len();
            if (stall_gap != 0) begin
                res_stall  <= 1'b1;
                stall_left <= stall_gap - 1;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            idle_cycles <= 0;
        end else if ((item_valid && !item_stall) || (res_valid && !res_stall) ||
                     (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        cur_w = eff_size(CFG_DATA_W'(RST_WIDTH));
        cur_h = eff_size(CFG_DATA_W'(RST_HEIGHT));
        cur_c = longint'($signed(RST_COS));
        cur_s = longint'($signed(RST_SIN));
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: cosine 16384, sine 0, 120x120
        write_pixel(0, 0, 4'd0);
        query_pixel(119, 0);
        query_pixel(0, 0);
        query_pixel(119, 119);
        write_pixel(127, 127, 4'd15);
        query_pixel(127, 127);
        query_pixel(120, 5);
        drain();

        // zero size, trig outside its range, unused register index
        program_regs(16'h0000, 16'hFF00, 16'h8000, 16'h7FFF, 1'b1);
        query_pixel(0, 0);
        query_pixel(1, 0);
        query_pixel(0, 1);
        query_pixel(127, 127);
        drain();

        // saturated size at 45 degrees, corners map outside
        program_regs(16'h00FF, 16'h0080, 16'sd11585, 16'sd11585, 1'b0);
        query_pixel(0, 0);
        query_pixel(127, 0);
        query_pixel(0, 127);
        query_pixel(127, 127);
        query_pixel(64, 64);
        query_pixel(63, 64);
        drain();

        program_regs(16'h5502, 16'hAA03, -16'sd16384, -16'sd16384, 1'b0);
        query_pixel(0, 0);
        query_pixel(1, 2);
        query_pixel(1, 1);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            program_regs(pick_size(), pick_size(), pick_trig(), pick_trig(),
                         $urandom_range(0, 3) == 0);
            calm = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_WORDS; n++) random_item();
            drain();
        end

        if (err_count == 0 && pend_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
